// ===== hdl/accumulator_alu_with_flags_macros.svh =====
// Assertion macros for the accumulator ALU checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ACCUMULATOR_ALU_WITH_FLAGS_MACROS_SVH
`define ACCUMULATOR_ALU_WITH_FLAGS_MACROS_SVH

// Checked only while the block is out of reset.
`define ACC_ALU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, including during reset.
`define ACC_ALU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/acc_alu_pkg.sv =====
// Package for the accumulator ALU: operation codes, illegal opcodes and flag positions.
// It has no dependencies.
`default_nettype none

package acc_alu_pkg;

  typedef enum logic [3:0] {
    OP_SUB  = 4'h0,
    OP_CMP  = 4'h1,
    OP_SBC  = 4'h2,
    OP_SUBD = 4'h3,
    OP_AND  = 4'h4,
    OP_BIT  = 4'h5,
    OP_LD   = 4'h6,
    OP_ST   = 4'h7,
    OP_EOR  = 4'h8,
    OP_ADC  = 4'h9,
    OP_OR   = 4'hA,
    OP_ADD  = 4'hB,
    OP_CMPX = 4'hC,
    OP_STD  = 4'hD,
    OP_LDX  = 4'hE,
    OP_STX  = 4'hF
  } alu_op_t;

  localparam logic [7:0] ILL_87 = 8'h87;
  localparam logic [7:0] ILL_8F = 8'h8F;
  localparam logic [7:0] ILL_C7 = 8'hC7;
  localparam logic [7:0] ILL_CD = 8'hCD;
  localparam logic [7:0] ILL_CF = 8'hCF;

  localparam int unsigned CC_BIT_H = 5;
  localparam int unsigned CC_BIT_C = 0;

endpackage

`default_nettype wire

// ===== hdl/accumulator_alu_with_flags.sv =====
// Top level of the accumulator ALU with condition codes.
// Depends on acc_alu_pkg.
`default_nettype none

// Usage:
// The input channel (in_valid, in_ready, opcode, operand) carries one
// instruction per transaction: an opcode from 0x80 to 0xFF and its fetched
// operand. The output channel (out_valid, out_ready, result_value, flags,
// write_mem, write_wide, write_data, illegal) returns one transaction per
// instruction, in order.
// An accepted instruction is held in an input register, where the adder and
// flag logic read it together with A, B, X, U and the condition codes; the
// registers and the result register load when the result register is free.
// The result is thus presented from the result register, after the input register.
// Throughput is one instruction per cycle while the receiver does not stall, set
// by the single adder pass and the register feedback into the next instruction.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready falls only when both are occupied.
// Reset clears A, B, X, U, the condition codes and both valid flags.
module accumulator_alu_with_flags (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  opcode,
  input  wire logic [15:0] operand,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      result_value,
  output logic [7:0]       flags,
  output logic             write_mem,
  output logic             write_wide,
  output logic [15:0]      write_data,
  output logic             illegal
);

  logic        stage_valid;
  logic [7:0]  stage_opcode;
  logic [15:0] stage_operand;
  logic [7:0]  acc_a;
  logic [7:0]  acc_b;
  logic [15:0] index_x;
  logic [15:0] user_stack;
  logic [7:0]  cond_codes;

  logic advance;

  logic [7:0]            code;
  logic                  bside;
  acc_alu_pkg::alu_op_t  op;
  logic [7:0]            acc;
  logic [7:0]            op8;
  logic [15:0]           dreg;
  logic                  is_illegal;

  logic                  sub8;
  logic                  usec8;
  logic                  cin8;
  logic [7:0]            o8;
  logic [8:0]            sum8;
  logic [4:0]            half8;
  logic [7:0]            r8;
  logic [7:0]            cc8;

  logic                  sub16;
  logic [15:0]           a16;
  logic [15:0]           o16;
  logic [16:0]           sum16;
  logic [15:0]           r16;
  logic [7:0]            cc16;

  logic [7:0]            logic_val;
  logic [7:0]            cc_nz8;
  logic [7:0]            cc_nz16_op;

  logic [15:0]           result_next;
  logic [7:0]            cc_next;
  logic [7:0]            acc_a_next;
  logic [7:0]            acc_b_next;
  logic [15:0]           index_x_next;
  logic [15:0]           user_stack_next;
  logic                  wmem_next;
  logic                  wwide_next;
  logic [15:0]           wdata_next;

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  assign code  = {1'b1, stage_opcode[6:0]};
  assign bside = code[6];
  assign op    = acc_alu_pkg::alu_op_t'(code[3:0]);
  assign acc   = bside ? acc_b : acc_a;
  assign op8   = stage_operand[7:0];
  assign dreg  = {acc_a, acc_b};

  assign is_illegal = (code == acc_alu_pkg::ILL_87) || (code == acc_alu_pkg::ILL_8F) ||
                      (code == acc_alu_pkg::ILL_C7) || (code == acc_alu_pkg::ILL_CD) ||
                      (code == acc_alu_pkg::ILL_CF);

  // Shared 8-bit adder; subtraction adds the complemented operand.
  assign sub8  = (op == acc_alu_pkg::OP_SUB) || (op == acc_alu_pkg::OP_CMP) ||
                 (op == acc_alu_pkg::OP_SBC);
  assign usec8 = (op == acc_alu_pkg::OP_SBC) || (op == acc_alu_pkg::OP_ADC);
  assign cin8  = sub8 ^ (usec8 && cond_codes[acc_alu_pkg::CC_BIT_C]);
  assign o8    = sub8 ? ~op8 : op8;
  assign sum8  = {1'b0, acc} + {1'b0, o8} + {8'h00, cin8};
  assign half8 = {1'b0, acc[3:0]} + {1'b0, o8[3:0]} + {4'h0, cin8};
  assign r8    = sum8[7:0];
  assign cc8   = {cond_codes[7:6], half8[4], cond_codes[4], r8[7], (r8 == 8'h00),
                  ((acc[7] ^ r8[7]) & (o8[7] ^ r8[7])), sum8[8] ^ sub8};

  // Shared 16-bit adder for SUBD, ADDD and CMPX.
  assign sub16 = (op == acc_alu_pkg::OP_SUBD) ? !bside : 1'b1;
  assign a16   = (op == acc_alu_pkg::OP_CMPX) ? index_x : dreg;
  assign o16   = sub16 ? ~stage_operand : stage_operand;
  assign sum16 = {1'b0, a16} + {1'b0, o16} + {16'h0000, sub16};
  assign r16   = sum16[15:0];
  assign cc16  = {cond_codes[7:4], r16[15], (r16 == 16'h0000),
                  ((a16[15] ^ r16[15]) & (o16[15] ^ r16[15])), sum16[16] ^ sub16};

  always_comb begin
    logic_val = 8'h00;
    case (op)
      acc_alu_pkg::OP_AND, acc_alu_pkg::OP_BIT: logic_val = acc & op8;
      acc_alu_pkg::OP_LD:                       logic_val = op8;
      acc_alu_pkg::OP_ST:                       logic_val = acc;
      acc_alu_pkg::OP_EOR:                      logic_val = acc ^ op8;
      acc_alu_pkg::OP_OR:                       logic_val = acc | op8;
      default:                                  logic_val = 8'h00;
    endcase
  end

  assign cc_nz8 = {cond_codes[7:4], logic_val[7], (logic_val == 8'h00), 1'b0,
                   cond_codes[0]};

  always_comb begin
    result_next     = 16'h0000;
    cc_next         = cond_codes;
    acc_a_next      = acc_a;
    acc_b_next      = acc_b;
    index_x_next    = index_x;
    user_stack_next = user_stack;
    wmem_next       = 1'b0;
    wwide_next      = 1'b0;
    wdata_next      = 16'h0000;
    cc_nz16_op      = 8'h00;
    if (!is_illegal) begin
      case (op)
        acc_alu_pkg::OP_SUB, acc_alu_pkg::OP_SBC, acc_alu_pkg::OP_ADC,
        acc_alu_pkg::OP_ADD: begin
          result_next = {8'h00, r8};
          cc_next     = cc8;
          if (bside) begin
            acc_b_next = r8;
          end else begin
            acc_a_next = r8;
          end
        end
        acc_alu_pkg::OP_CMP: begin
          result_next = {8'h00, r8};
          cc_next     = cc8;
        end
        acc_alu_pkg::OP_SUBD: begin
          result_next = r16;
          cc_next     = cc16;
          acc_a_next  = r16[15:8];
          acc_b_next  = r16[7:0];
        end
        acc_alu_pkg::OP_AND, acc_alu_pkg::OP_LD, acc_alu_pkg::OP_EOR,
        acc_alu_pkg::OP_OR: begin
          result_next = {8'h00, logic_val};
          cc_next     = cc_nz8;
          if (bside) begin
            acc_b_next = logic_val;
          end else begin
            acc_a_next = logic_val;
          end
        end
        acc_alu_pkg::OP_BIT: begin
          result_next = {8'h00, logic_val};
          cc_next     = cc_nz8;
        end
        acc_alu_pkg::OP_ST: begin
          result_next = {8'h00, logic_val};
          cc_next     = cc_nz8;
          wmem_next   = 1'b1;
          wdata_next  = {8'h00, logic_val};
        end
        acc_alu_pkg::OP_CMPX: begin
          if (bside) begin
            result_next = stage_operand;
            cc_next     = {cond_codes[7:4], stage_operand[15],
                           (stage_operand == 16'h0000), 1'b0, cond_codes[0]};
            acc_a_next  = stage_operand[15:8];
            acc_b_next  = stage_operand[7:0];
          end else begin
            result_next = r16;
            cc_next     = cc16;
          end
        end
        acc_alu_pkg::OP_STD: begin
          if (bside) begin
            result_next = dreg;
            cc_next     = {cond_codes[7:4], dreg[15], (dreg == 16'h0000), 1'b0,
                           cond_codes[0]};
            wmem_next   = 1'b1;
            wwide_next  = 1'b1;
            wdata_next  = dreg;
          end
        end
        acc_alu_pkg::OP_LDX: begin
          result_next = stage_operand;
          cc_next     = {cond_codes[7:4], stage_operand[15],
                         (stage_operand == 16'h0000), 1'b0, cond_codes[0]};
          if (bside) begin
            user_stack_next = stage_operand;
          end else begin
            index_x_next = stage_operand;
          end
        end
        acc_alu_pkg::OP_STX: begin
          cc_nz16_op  = 8'h00;
          result_next = bside ? user_stack : index_x;
          cc_next     = {cond_codes[7:4], result_next[15], (result_next == 16'h0000),
                         1'b0, cond_codes[0]};
          wmem_next   = 1'b1;
          wwide_next  = 1'b1;
          wdata_next  = result_next;
        end
        default: begin
          cc_nz16_op = 8'h00;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_opcode  <= opcode;
      stage_operand <= operand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      acc_a      <= 8'h00;
      acc_b      <= 8'h00;
      index_x    <= 16'h0000;
      user_stack <= 16'h0000;
      cond_codes <= 8'h00;
    end else begin
      if (advance) begin
        out_valid  <= 1'b1;
        acc_a      <= acc_a_next;
        acc_b      <= acc_b_next;
        index_x    <= index_x_next;
        user_stack <= user_stack_next;
        cond_codes <= cc_next | cc_nz16_op;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_value <= result_next;
      flags        <= cc_next | cc_nz16_op;
      write_mem    <= wmem_next;
      write_wide   <= wwide_next;
      write_data   <= wdata_next;
      illegal      <= is_illegal;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/acc_alu_checker.sv =====
// Port-level checker for accumulator_alu_with_flags, attached by bind.
// Depends on accumulator_alu_with_flags_macros.svh.
`default_nettype none
`include "accumulator_alu_with_flags_macros.svh"

module acc_alu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  opcode,
  input wire logic [15:0] operand,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] result_value,
  input wire logic [7:0]  flags,
  input wire logic        write_mem,
  input wire logic        write_wide,
  input wire logic [15:0] write_data,
  input wire logic        illegal
);

  `ACC_ALU_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "out_valid set after reset")
  `ACC_ALU_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable({opcode, operand}), "waiting input changed")
  `ACC_ALU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(flags), "stalled result changed")
  `ACC_ALU_ASSERT(a_no_store_data, out_valid && !write_mem |-> write_data == 16'h0000 && !write_wide, "store data without a store")
  `ACC_ALU_ASSERT(a_illegal_quiet, out_valid && illegal |-> !write_mem && result_value == 16'h0000, "illegal opcode produced a result")

endmodule

bind accumulator_alu_with_flags acc_alu_checker u_acc_alu_checker (.*);

`default_nettype wire
